[hdl/srq_pkg.sv]
`timescale 1ns / 1ps

package srq_pkg;

    // default geometry
    localparam int SRQ_FRAC_BITS    = 16;
    localparam int SRQ_SAMPLE_WIDTH = 16;

    // step register
    localparam int                   SRQ_STEP_W     = 18;
    localparam logic [SRQ_STEP_W-1:0] SRQ_STEP_RESET = 18'd65536;

    // outputs per input request at most
    localparam int SRQ_MAX_RESULTS = 8;

    // fraction handed to the lanes, always 16 bits
    localparam int SRQ_FQ_W = 16;

    // result buffer depth
    localparam int SRQ_FIFO_DEPTH = 8;

    // control travelling alongside the lane data
    typedef struct packed {
        logic valid;
        logic last;
    } srq_tag_t;

endpackage

[hdl/srq_if.sv]
`timescale 1ns / 1ps

// input frame channel
interface srq_in_if
    import srq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SRQ_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] in_left;
    logic signed [SAMPLE_WIDTH-1:0] in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

// output frame channel
interface srq_out_if
    import srq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SRQ_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] out_left;
    logic signed [SAMPLE_WIDTH-1:0] out_right;
    logic                           last_of_run;

    modport source (output valid, output out_left, output out_right, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_left, input out_right, input last_of_run,
                    output ready);
endinterface

// step register write channel
interface srq_cfg_if
    import srq_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [SRQ_STEP_W-1:0] phase_step;

    modport source (output valid, output phase_step, input ready);
    modport sink   (input valid, input phase_step, output ready);
endinterface

[hdl/srq_lane.sv]
`timescale 1ns / 1ps

module srq_lane
    import srq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SRQ_SAMPLE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  srq_tag_t                       tag_in,
    input  logic        [SRQ_FQ_W-1:0]     fq,
    input  logic signed [SAMPLE_WIDTH-1:0] y0,
    input  logic signed [SAMPLE_WIDTH-1:0] y1,
    input  logic signed [SAMPLE_WIDTH-1:0] y2,
    output srq_tag_t                       tag_out,
    output logic signed [SAMPLE_WIDTH-1:0] result
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int D1_W  = SW + 1;
    localparam int D2_W  = SW + 2;
    localparam int P1_W  = D1_W + SRQ_FQ_W + 1;
    localparam int FF_W  = 2 * SRQ_FQ_W;
    localparam int P2_W  = D2_W + FF_W + 1;
    localparam int SHIFT = 2 * SRQ_FQ_W + 1;
    localparam int NUM_W = SW + 36;
    localparam int V_W   = NUM_W - SHIFT;

    localparam logic signed [V_W-1:0] V_MAX = V_W'({1'b0, {(SW-1){1'b1}}});
    localparam logic signed [V_W-1:0] V_MIN = -V_MAX - V_W'(1);
    localparam logic signed [NUM_W-1:0] BIAS = NUM_W'(1) <<< (SHIFT - 1);

    srq_tag_t tag_reg [4];

    // stage 1: first products
    logic        [FF_W-1:0]  ff_reg,  ff_next;
    logic signed [P1_W-1:0]  p1a_reg, p1a_next;
    logic signed [D2_W-1:0]  d2_reg,  d2_next;
    logic signed [SW-1:0]    y1a_reg;
    logic signed [D1_W-1:0]  d1;

    // stage 2: curvature term
    logic signed [P2_W-1:0]  p2_reg,  p2_next;
    logic signed [P1_W-1:0]  p1b_reg;
    logic signed [SW-1:0]    y1b_reg;

    // stage 3: sum, stage 4: round and clip
    logic signed [NUM_W-1:0] num_reg, num_next;
    logic signed [NUM_W-1:0] rounded;
    logic signed [V_W-1:0]   v;
    logic signed [SW-1:0]    result_reg, result_next;

    always_comb
    begin
        d1       = D1_W'(y2) - D1_W'(y0);
        d2_next  = D2_W'(y0) + D2_W'(y2) - (D2_W'(y1) <<< 1);
        ff_next  = FF_W'(fq) * FF_W'(fq);
        p1a_next = P1_W'(d1) * $signed(P1_W'({1'b0, fq}));
    end

    always_comb
    begin
        p2_next = P2_W'(d2_reg) * $signed(P2_W'({1'b0, ff_reg}));
    end

    always_comb
    begin
        num_next = (NUM_W'(y1b_reg) <<< SHIFT) + (NUM_W'(p1b_reg) <<< SRQ_FQ_W)
                 + NUM_W'(p2_reg);
    end

    // round half up, then clip to the sample range
    always_comb
    begin
        rounded = (num_reg + BIAS) >>> SHIFT;
        v       = rounded[V_W-1:0];
        if (v > V_MAX)
            result_next = V_MAX[SW-1:0];
        else if (v < V_MIN)
            result_next = V_MIN[SW-1:0];
        else
            result_next = v[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                tag_reg[i] <= '0;
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < 4; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        ff_reg     <= ff_next;
        p1a_reg    <= p1a_next;
        d2_reg     <= d2_next;
        y1a_reg    <= y1;
        p2_reg     <= p2_next;
        p1b_reg    <= p1a_reg;
        y1b_reg    <= y1a_reg;
        num_reg    <= num_next;
        result_reg <= result_next;
    end

    assign tag_out = tag_reg[3];
    assign result  = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        tag_in.valid |-> ##4 tag_out.valid)
        else $error("lane result did not appear four cycles after issue");

    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        tag_in.valid && tag_in.last |-> ##4 (tag_out.valid && tag_out.last))
        else $error("lane lost the end-of-run mark");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !tag_in.valid |-> ##4 !tag_out.valid)
        else $error("lane produced a result with no issue");

endmodule

[hdl/srq_merge.sv]
`timescale 1ns / 1ps

module srq_merge
    import srq_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SRQ_SAMPLE_WIDTH,
    parameter int FIFO_DEPTH   = SRQ_FIFO_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           issue,
    output logic                           can_issue,
    input  srq_tag_t                       tag_l,
    input  srq_tag_t                       tag_r,
    input  logic signed [SAMPLE_WIDTH-1:0] res_l,
    input  logic signed [SAMPLE_WIDTH-1:0] res_r,
    srq_out_if.source                      out_frame
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(FIFO_DEPTH - 1);

    logic signed [SAMPLE_WIDTH-1:0] left_mem  [FIFO_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] right_mem [FIFO_DEPTH];
    logic                           last_mem  [FIFO_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [CNT_W-1:0] credit_reg, credit_next;
    logic             wr_en;
    logic             rd_en;

    // both lanes run in lock step, the left tag speaks for the pair
    assign wr_en = tag_l.valid;
    assign rd_en = out_frame.valid && out_frame.ready;

    // credits cover frames in the lanes plus frames buffered
    assign can_issue = credit_reg < DEPTH_C;

    always_comb
    begin
        wr_ptr_next = wr_en ? ((wr_ptr_reg == LAST_P) ? '0 : wr_ptr_reg + PTR_W'(1))
                            : wr_ptr_reg;
        rd_ptr_next = rd_en ? ((rd_ptr_reg == LAST_P) ? '0 : rd_ptr_reg + PTR_W'(1))
                            : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
        credit_next = credit_reg + CNT_W'(issue) - CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_ptr_reg]  <= res_l;
            right_mem[wr_ptr_reg] <= res_r;
            last_mem[wr_ptr_reg]  <= tag_l.last;
        end
    end

    assign out_frame.valid       = count_reg != '0;
    assign out_frame.out_left    = left_mem[rd_ptr_reg];
    assign out_frame.out_right   = right_mem[rd_ptr_reg];
    assign out_frame.last_of_run = last_mem[rd_ptr_reg];

    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        tag_l == tag_r)
        else $error("left and right lanes out of step");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg < DEPTH_C) || rd_en)
        else $error("result buffer written while full");

    a_credit_covers: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg >= count_reg && credit_reg <= DEPTH_C)
        else $error("credit count out of range");

endmodule

[hdl/stereo_quadratic_resampler_core.sv]
`timescale 1ns / 1ps

// stereo quadratic resampler: each input request carries one stereo frame,
// which is pushed into a three-frame history (cleared at reset). a sequencer
// then walks the read position from the middle frame towards the newest one,
// issuing one output position per cycle while the integer part is zero, up to
// eight per input, stepping by phase_step (unsigned, 16 fraction bits). each
// issued position goes to two identical lanes, one per channel, which fit the
// quadratic through the three frames in a four-stage multiply pipeline and
// round half up and clip to the sample range; a merge stage pairs the lane
// results into output frames in an eight-entry buffer, and the final frame an
// input causes carries last_of_run. an input causes 0 to 8 output frames,
// issued by the sequencer one position at a time; a new frame is taken only
// once the sequencer is idle. each output frame passes through the lane
// stages and the merge buffer. issue is held back by buffer credits when the
// output side stalls. phase_step may be written only while the block is idle.
module stereo_quadratic_resampler_core
    import srq_pkg::*;
#(
    parameter int FRAC_BITS    = SRQ_FRAC_BITS,
    parameter int SAMPLE_WIDTH = SRQ_SAMPLE_WIDTH,
    parameter int FIFO_DEPTH   = SRQ_FIFO_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    srq_cfg_if.sink   cfg,
    srq_in_if.sink    in_frame,
    srq_out_if.source out_frame
);

    localparam int POS_W = FRAC_BITS + 4;
    localparam int SUM_W = ((POS_W > SRQ_STEP_W) ? POS_W : SRQ_STEP_W) + 1;
    localparam int N_W   = $clog2(SRQ_MAX_RESULTS + 1);
    localparam int DOWN_SH = (FRAC_BITS > SRQ_FQ_W) ? (FRAC_BITS - SRQ_FQ_W) : 0;
    localparam int UP_SH   = (FRAC_BITS < SRQ_FQ_W) ? (SRQ_FQ_W - FRAC_BITS) : 0;
    localparam int FW_W    = FRAC_BITS + SRQ_FQ_W;

    localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] ONE_FRAME = POS_W'(1) << FRAC_BITS;
    localparam logic [N_W-1:0]   N_MAX     = N_W'(SRQ_MAX_RESULTS);
    localparam logic [N_W-1:0]   N_LAST    = N_W'(SRQ_MAX_RESULTS - 1);

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } srq_state_t;

    srq_state_t state_reg, state_next;

    // step register
    logic [SRQ_STEP_W-1:0] step_reg, step_next;

    // read position, measured from the middle frame
    logic [POS_W-1:0] pos_reg, pos_next;

    // outputs issued for the current input
    logic [N_W-1:0] n_reg, n_next;

    // frame history per channel: [0] oldest, [2] newest
    logic signed [SAMPLE_WIDTH-1:0] hist_l_reg [3];
    logic signed [SAMPLE_WIDTH-1:0] hist_r_reg [3];

    logic             in_accept;
    logic             more_due;
    logic             can_issue;
    logic             issue;
    logic             issue_last;
    logic             finish;
    logic [SUM_W-1:0] pos_sum;
    logic [POS_W-1:0] pos_adv;
    logic [POS_W-1:0] pos_back;
    logic [FW_W-1:0]  frac_wide;
    logic [SRQ_FQ_W-1:0] fq;
    srq_tag_t         issue_tag;

    srq_tag_t                       tag_l, tag_r;
    logic signed [SAMPLE_WIDTH-1:0] res_l, res_r;

    // the step register is always writable
    assign cfg.ready = 1'b1;
    assign step_next = (cfg.valid && cfg.ready) ? cfg.phase_step : step_reg;

    assign in_frame.ready = state_reg == ST_IDLE;
    assign in_accept      = in_frame.valid && in_frame.ready;

    // next position, held at all ones on overflow
    always_comb
    begin
        pos_sum = SUM_W'(pos_reg) + SUM_W'(step_reg);
        if (pos_sum > SUM_W'(POS_MAX))
            pos_adv = POS_MAX;
        else
            pos_adv = pos_sum[POS_W-1:0];
    end

    // move back one frame at the end of a run, floor at zero
    assign pos_back = (pos_reg >= ONE_FRAME) ? (pos_reg - ONE_FRAME) : '0;

    // fraction reduced or padded to the lane width
    always_comb
    begin
        frac_wide = FW_W'(pos_reg[FRAC_BITS-1:0]);
        fq        = SRQ_FQ_W'((frac_wide >> DOWN_SH) << UP_SH);
    end

    assign more_due   = (pos_reg[POS_W-1:FRAC_BITS] == '0) && (n_reg < N_MAX);
    assign issue      = (state_reg == ST_RUN) && more_due && can_issue;
    assign finish     = (state_reg == ST_RUN) && !more_due;
    assign issue_last = (n_reg == N_LAST) || (pos_adv[POS_W-1:FRAC_BITS] != '0);

    assign issue_tag.valid = issue;
    assign issue_tag.last  = issue_last;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        n_next     = n_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    n_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    pos_next = pos_adv;
                    n_next   = n_reg + N_W'(1);
                end
                else if (finish)
                begin
                    pos_next   = pos_back;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= SRQ_STEP_RESET;
            pos_reg   <= '0;
            n_reg     <= '0;
            for (int i = 0; i < 3; i++)
            begin
                hist_l_reg[i] <= '0;
                hist_r_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pos_reg   <= pos_next;
            n_reg     <= n_next;
            if (in_accept)
            begin
                hist_l_reg[0] <= hist_l_reg[1];
                hist_l_reg[1] <= hist_l_reg[2];
                hist_l_reg[2] <= in_frame.in_left;
                hist_r_reg[0] <= hist_r_reg[1];
                hist_r_reg[1] <= hist_r_reg[2];
                hist_r_reg[2] <= in_frame.in_right;
            end
        end
    end

    // one lane per channel
    srq_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_l (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (issue_tag),
        .fq      (fq),
        .y0      (hist_l_reg[0]),
        .y1      (hist_l_reg[1]),
        .y2      (hist_l_reg[2]),
        .tag_out (tag_l),
        .result  (res_l)
    );

    srq_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (issue_tag),
        .fq      (fq),
        .y0      (hist_r_reg[0]),
        .y1      (hist_r_reg[1]),
        .y2      (hist_r_reg[2]),
        .tag_out (tag_r),
        .result  (res_r)
    );

    // pair lane results into frames and buffer them
    srq_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FIFO_DEPTH   (FIFO_DEPTH)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .can_issue (can_issue),
        .tag_l     (tag_l),
        .tag_r     (tag_r),
        .res_l     (res_l),
        .res_r     (res_r),
        .out_frame (out_frame)
    );

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_RUN) && (n_reg == '0))
        else $error("accepted frame did not start a run");

    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_MAX)
        else $error("too many outputs issued for one input");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        issue && issue_last |=> !issue && finish)
        else $error("run continued after its final output");

    a_finish_idles: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle");

endmodule
